>>> hdl/ecd_pkg.sv
// Shared types and constants for the element-wise complex divider.
`default_nettype none

package ecd_pkg;

  localparam int QuotWidth = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SAT      = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> hdl/elementwise_complex_divider_unit.sv
// Top level of the element-wise complex divider.
//
//   channel | handshake                | payload
//   --------+--------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o  | num_re_i num_im_i den_re_i den_im_i
//   out     | out_valid_o / out_ready_i| quot_re_o quot_im_o status_o
//
// One transaction per cycle sustained while the output is not stalled; the path runs through
// 3 front stages, the queue, 32 divider stages (one quotient bit each) and the output register.
// The 32-stage restoring divider pipeline dominates the latency; its width follows IN_WIDTH.
// Reset clears only valid and queue pointers; no clearing pass is needed.
// An output stall holds the divider; the front end keeps taking transactions until
// the two-entry queue fills, then drops in_ready_o.
`default_nettype none

module elementwise_complex_divider_unit
  import ecd_pkg::*;
#(
  parameter int IN_WIDTH  = 24,
  parameter int FRAC_BITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [IN_WIDTH-1:0]  num_re_i,
  input  wire logic [IN_WIDTH-1:0]  num_im_i,
  input  wire logic [IN_WIDTH-1:0]  den_re_i,
  input  wire logic [IN_WIDTH-1:0]  den_im_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [QuotWidth-1:0]      quot_re_o,
  output logic [QuotWidth-1:0]      quot_im_o,
  output logic [1:0]                status_o
);

  localparam int EW = 1 + 2 * IN_WIDTH + 2 * (2 + 2 * IN_WIDTH + 1 + QuotWidth);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  ecd_front #(
    .IN_WIDTH (IN_WIDTH),
    .FRAC_BITS(FRAC_BITS),
    .EW       (EW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .num_re_i    (num_re_i),
    .num_im_i    (num_im_i),
    .den_re_i    (den_re_i),
    .den_im_i    (den_im_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ecd_fifo #(
    .EW(EW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  ecd_back #(
    .IN_WIDTH(IN_WIDTH),
    .EW      (EW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .quot_re_o  (quot_re_o),
    .quot_im_o  (quot_im_o),
    .status_o   (status_o)
  );

endmodule

`default_nettype wire

>>> hdl/ecd_front.sv
// Front end: accepts bins, forms products, sums and divisor, classifies each transaction.
`default_nettype none

module ecd_front
  import ecd_pkg::*;
#(
  parameter int IN_WIDTH  = 24,
  parameter int FRAC_BITS = 20,
  parameter int EW        = 1 + 2 * IN_WIDTH + 2 * (2 + 2 * IN_WIDTH + 1 + QuotWidth)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [IN_WIDTH-1:0] num_re_i,
  input  wire logic [IN_WIDTH-1:0] num_im_i,
  input  wire logic [IN_WIDTH-1:0] den_re_i,
  input  wire logic [IN_WIDTH-1:0] den_im_i,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i,
  output logic [EW-1:0]            push_data_o
);

  localparam int DW = 2 * IN_WIDTH;
  localparam int RW = DW + 1;
  localparam int CW = DW + QuotWidth;

  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic [RW-1:0]        rem;
    logic [QuotWidth-1:0] low;
  } part_t;

  typedef struct packed {
    logic          zero;
    logic [DW-1:0] den;
    part_t         re;
    part_t         im;
  } entry_t;

  function automatic logic [IN_WIDTH-1:0] abs_val(input logic [IN_WIDTH-1:0] x);
    abs_val = x[IN_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DW:0] apply_sign(input logic [DW-1:0] p, input logic s);
    apply_sign = s ? (~{1'b0, p} + 1'b1) : {1'b0, p};
  endfunction

  function automatic part_t prep_part(input logic [DW-1:0] mag, input logic neg,
                                      input logic [DW-1:0] den);
    logic [CW-1:0] nsh;
    logic [CW-1:0] dsh;
    part_t         r;
    nsh   = CW'(mag) << FRAC_BITS;
    dsh   = {den, {QuotWidth{1'b0}}};
    r.neg = neg;
    r.big = (nsh >= dsh);
    r.rem = RW'(mag >> (QuotWidth - FRAC_BITS));
    r.low = nsh[QuotWidth-1:0];
    return r;
  endfunction

  logic en;

  // stage 1: magnitudes multiplied
  logic          v1_q;
  logic [DW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_br_q, p_bi_q;
  logic          s_rr_q, s_ii_q, s_ir_q, s_ri_q;

  // stage 2: signed sums and divisor
  logic          v2_q;
  logic [DW-1:0] nre_mag_q, nim_mag_q, den_q;
  logic          nre_neg_q, nim_neg_q;

  // stage 3: classified entry
  logic          v3_q;
  entry_t        ent_q;

  logic [IN_WIDTH-1:0] ar, ai, br, bi;
  logic [DW:0]         nre_sum, nim_sum, nre_neg_sum, nim_neg_sum;
  logic [DW-1:0]       den_sum;

  assign ar = abs_val(num_re_i);
  assign ai = abs_val(num_im_i);
  assign br = abs_val(den_re_i);
  assign bi = abs_val(den_im_i);

  assign nre_sum     = apply_sign(p_rr_q, s_rr_q) + apply_sign(p_ii_q, s_ii_q);
  assign nim_sum     = apply_sign(p_ir_q, s_ir_q) + apply_sign(p_ri_q, ~s_ri_q);
  assign nre_neg_sum = ~nre_sum + 1'b1;
  assign nim_neg_sum = ~nim_sum + 1'b1;
  assign den_sum     = p_br_q + p_bi_q;

  // hold every stage while stage 3 holds an entry and the queue is full
  assign en           = !v3_q || push_ready_i;
  assign in_ready_o   = en;
  assign push_valid_o = v3_q;
  assign push_data_o  = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rr_q <= DW'(ar) * DW'(br);
      p_ii_q <= DW'(ai) * DW'(bi);
      p_ir_q <= DW'(ai) * DW'(br);
      p_ri_q <= DW'(ar) * DW'(bi);
      p_br_q <= DW'(br) * DW'(br);
      p_bi_q <= DW'(bi) * DW'(bi);
      s_rr_q <= num_re_i[IN_WIDTH-1] ^ den_re_i[IN_WIDTH-1];
      s_ii_q <= num_im_i[IN_WIDTH-1] ^ den_im_i[IN_WIDTH-1];
      s_ir_q <= num_im_i[IN_WIDTH-1] ^ den_re_i[IN_WIDTH-1];
      s_ri_q <= num_re_i[IN_WIDTH-1] ^ den_im_i[IN_WIDTH-1];

      nre_neg_q <= nre_sum[DW];
      nim_neg_q <= nim_sum[DW];
      nre_mag_q <= nre_sum[DW] ? nre_neg_sum[DW-1:0] : nre_sum[DW-1:0];
      nim_mag_q <= nim_sum[DW] ? nim_neg_sum[DW-1:0] : nim_sum[DW-1:0];
      den_q     <= den_sum;

      ent_q.zero <= (den_q == '0);
      ent_q.den  <= den_q;
      ent_q.re   <= prep_part(nre_mag_q, nre_neg_q, den_q);
      ent_q.im   <= prep_part(nim_mag_q, nim_neg_q, den_q);
    end
  end

endmodule

`default_nettype wire

>>> hdl/ecd_fifo.sv
// Two-entry queue between the front end and the divider pipeline.
`default_nettype none

module ecd_fifo #(
  parameter int EW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire logic [EW-1:0] push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output logic [EW-1:0]      pop_data_o
);

  localparam int Depth = 2;
  localparam int PW    = $clog2(Depth);

  logic [EW-1:0] mem_q [Depth];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != (PW + 1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> hdl/ecd_back.sv
// Back end: pipelined restoring division, one quotient bit per stage, then saturation and divide-by-zero status.
`default_nettype none

module ecd_back
  import ecd_pkg::*;
#(
  parameter int IN_WIDTH = 24,
  parameter int EW       = 1 + 2 * IN_WIDTH + 2 * (2 + 2 * IN_WIDTH + 1 + QuotWidth)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_valid_i,
  output logic               pop_ready_o,
  input  wire logic [EW-1:0] pop_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [QuotWidth-1:0] quot_re_o,
  output logic [QuotWidth-1:0] quot_im_o,
  output logic [1:0]           status_o
);

  localparam int DW     = 2 * IN_WIDTH;
  localparam int RW     = DW + 1;
  localparam int Stages = QuotWidth;

  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic [RW-1:0]        rem;
    logic [QuotWidth-1:0] low;
  } part_t;

  typedef struct packed {
    logic          zero;
    logic [DW-1:0] den;
    part_t         re;
    part_t         im;
  } entry_t;

  function automatic part_t step_part(input part_t p, input logic [DW-1:0] den);
    logic [RW-1:0] t;
    logic [RW:0]   diff;
    part_t         r;
    r    = p;
    t    = {p.rem[RW-2:0], p.low[QuotWidth-1]};
    diff = {1'b0, t} - {2'b00, den};
    if (!diff[RW]) begin
      r.rem = diff[RW-1:0];
      r.low = {p.low[QuotWidth-2:0], 1'b1};
    end else begin
      r.rem = t;
      r.low = {p.low[QuotWidth-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [QuotWidth:0] finish_part(input part_t p);
    logic [QuotWidth-1:0] lim;
    logic [QuotWidth-1:0] mag;
    logic                 sat;
    lim = p.neg ? {1'b1, {(QuotWidth - 1){1'b0}}} : {1'b0, {(QuotWidth - 1){1'b1}}};
    sat = p.big || (p.low > lim);
    mag = sat ? lim : p.low;
    finish_part = {sat, (p.neg ? (~mag + 1'b1) : mag)};
  endfunction

  logic                en;
  logic [Stages-1:0]   vld_q;
  entry_t              st_q [Stages];
  entry_t              st_d [Stages];
  entry_t              head;
  logic [QuotWidth:0]  fin_re, fin_im;

  logic                 out_valid_q;
  logic [QuotWidth-1:0] quot_re_q, quot_im_q;
  status_e              status_q;

  assign head = pop_data_i;

  // advance the whole pipeline unless a finished result is stuck at the output
  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) st_d[k] = head;
      else        st_d[k] = st_q[k-1];
      st_d[k].re = step_part(st_d[k].re, st_d[k].den);
      st_d[k].im = step_part(st_d[k].im, st_d[k].den);
    end
  end

  assign fin_re = finish_part(st_q[Stages-1].re);
  assign fin_im = finish_part(st_q[Stages-1].im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Stages-2:0], pop_valid_i};
      out_valid_q <= vld_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Stages; k++) st_q[k] <= st_d[k];
      if (st_q[Stages-1].zero) begin
        quot_re_q <= '0;
        quot_im_q <= '0;
        status_q  <= STATUS_DIV_ZERO;
      end else begin
        quot_re_q <= fin_re[QuotWidth-1:0];
        quot_im_q <= fin_im[QuotWidth-1:0];
        status_q  <= (fin_re[QuotWidth] || fin_im[QuotWidth]) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign quot_re_o   = quot_re_q;
  assign quot_im_o   = quot_im_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
